// ----- sv/recency_ordered_id_list_core_macros.svh -----
// Assertion helpers shared by the list core modules.
`ifndef RECENCY_ORDERED_ID_LIST_CORE_MACROS_SVH
`define RECENCY_ORDERED_ID_LIST_CORE_MACROS_SVH

// cond holds at every clock edge outside reset.
`define ROL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante.
`define ROL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante.
`define ROL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rol_pkg.sv -----
`default_nettype none

package rol_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;
  localparam int ID_FIELD_W   = 16;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_SWITCH = 2'd1,
    KIND_CLOSE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_LAST2,
    RD_SCAN,
    RD_SHIFT
  } rd_sel_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ID_FIELD_W-1:0] window_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] current_id;
    logic                  list_empty;
    logic [1:0]            status;
  } out_item_t;

  typedef struct packed {
    logic    load_in;
    logic    do_open;
    logic    set_cur_key;
    logic    pop_last;
    logic    fetch_cur;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    set_status;
    status_t status;
    rd_sel_t rd_sel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       cur_match;
    logic       hit;
    logic       exhausted;
    logic       shift_last;
    logic       out_ready;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/rol_ram.sv -----
`default_nettype none

module rol_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/rol_dpath.sv -----
`default_nettype none

module rol_dpath #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rol_pkg::in_item_t in_data,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output rol_pkg::out_item_t     out_data,
  input  wire rol_pkg::cmd_t     cmd,
  output rol_pkg::sts_t          sts
);

  import rol_pkg::*;

  `include "recency_ordered_id_list_core_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]          kind_r;
  logic [ID_WIDTH-1:0] key_r;
  logic [ID_WIDTH-1:0] cur_r,   cur_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r,   ptr_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  status_t             status_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic                list_empty;
  logic                shift_last;

  rol_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign list_empty = (count_r == '0);
  assign shift_last = ((ptr_r + CW'(1)) == count_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST2: ram_raddr = AW'(count_r - CW'(2));
      RD_SCAN:  ram_raddr = AW'(ptr_r);
      RD_SHIFT: ram_raddr = AW'(ptr_r + CW'(2));
      default:  ram_raddr = AW'(ptr_r);
    endcase
  end

  assign ram_we    = cmd.do_open | cmd.shift_step;
  assign ram_waddr = cmd.do_open ? AW'(count_r) : AW'(ptr_r);
  assign ram_wdata = (cmd.do_open | shift_last) ? key_r : ram_rdata;

  always_comb begin
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    ptr_nxt     = ptr_r;
    cmp_vld_nxt = cmp_vld_r;
    if (cmd.do_open) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_last) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.set_cur_key) begin
      cur_nxt = key_r;
    end else if (cmd.fetch_cur) begin
      cur_nxt = ram_rdata;
    end
    if (cmd.scan_start) begin
      ptr_nxt     = '0;
      cmp_vld_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      cmp_vld_nxt = (ptr_r < count_r);
      if (ptr_r < count_r) begin
        ptr_nxt = ptr_r + CW'(1);
      end
    end else if (cmd.shift_start) begin
      ptr_nxt     = ptr_r - CW'(1);
      cmp_vld_nxt = 1'b0;
    end else if (cmd.shift_step) begin
      ptr_nxt = ptr_r + CW'(1);
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ptr_r <= ptr_nxt;
    if (cmd.load_in) begin
      kind_r <= in_data.kind;
      key_r  <= ID_WIDTH'(in_data.window_id);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_data_r.current_id <= list_empty ? '0 : ID_FIELD_W'(cur_r);
      out_data_r.list_empty <= list_empty;
      out_data_r.status     <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.kind       = kind_r;
    sts.full       = (count_r == CW'(DEPTH));
    sts.empty      = list_empty;
    sts.cur_match  = (cur_r == key_r);
    sts.hit        = cmp_vld_r && (ram_rdata == key_r);
    sts.exhausted  = !cmp_vld_r && (ptr_r == count_r);
    sts.shift_last = shift_last;
    sts.out_ready  = !out_valid_r || !out_stall;
  end

  `ROL_ASSERT_ALWAYS(a_count_range, count_r <= CW'(DEPTH), "entry count above depth")
  `ROL_ASSERT_NXT(a_count_hold, !cmd.do_open && !cmd.pop_last, count_r == $past(count_r), "count moved without command")
  `ROL_ASSERT_IMP(a_shift_range, cmd.shift_step, ptr_r < count_r, "shift beyond list end")

endmodule

`default_nettype wire

// ----- sv/rol_ctrl.sv -----
`default_nettype none

module rol_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rol_pkg::sts_t sts,
  output rol_pkg::cmd_t      cmd
);

  import rol_pkg::*;

  `include "recency_ordered_id_list_core_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_SCAN;
    cmd.status = ST_OK;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_DONE;
        case (sts.kind)
          KIND_OPEN: begin
            if (sts.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.do_open     = 1'b1;
              cmd.set_cur_key = 1'b1;
            end
          end
          KIND_SWITCH: begin
            if (sts.empty) begin
              cmd.status = ST_EMPTY;
            end else if (!sts.cur_match) begin
              cmd.set_status = 1'b0;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          KIND_CLOSE: begin
            if (sts.empty) begin
              cmd.status = ST_EMPTY;
            end else if (sts.cur_match) begin
              cmd.pop_last = 1'b1;
              cmd.rd_sel   = RD_LAST2;
              state_nxt    = S_FETCH;
            end else begin
              cmd.set_status = 1'b0;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            cmd.status = ST_OK;
          end
        endcase
      end
      S_FETCH: begin
        cmd.fetch_cur = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        cmd.rd_sel = RD_SCAN;
        if (sts.hit) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else if (sts.exhausted) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.rd_sel     = RD_SHIFT;
        cmd.shift_step = 1'b1;
        if (sts.shift_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          if (sts.kind == KIND_CLOSE) begin
            cmd.pop_last = 1'b1;
          end else begin
            cmd.set_cur_key = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ROL_ASSERT_IMP(a_pop_nonempty, cmd.pop_last, !sts.empty, "removal from empty list")
  `ROL_ASSERT_IMP(a_open_room, cmd.do_open, !sts.full, "append into full list")
  `ROL_ASSERT_NXT(a_load_decode, cmd.load_in, state_r == S_DECODE, "accepted item not decoded")

endmodule

`default_nettype wire

// ----- sv/recency_ordered_id_list_core.sv -----
// Recency-ordered ID list. Holds up to DEPTH IDs, oldest first; the last one is current.
// Input channel in_valid/in_stall/in_data carries one command item (open, switch, close
// plus an ID). Result channel out_valid/out_stall/out_data returns exactly one item per
// command: current ID (zero when empty), empty flag and status.
// One command is in work at a time; the next is taken once the result is registered.
// Open, no-op and error items pass through the decode and done states before out_valid;
// close-current also passes a fetch state (it fetches the new last entry from the store). Switch and close of an
// inner entry scan the store one entry a cycle through its registered read port, then
// move the later entries down one a cycle. An unknown ID ends the scan with not-found status
// once every entry has been read.
// A new command is taken only in the idle state, after the previous result is loaded.
// Reset (rst_n low, synchronous) empties the list at once; there is no clearing pass.
// A stalled result stays in the output register; the block may accept and finish
// the next command meanwhile, and holds that result until the register frees up.
`default_nettype none

module recency_ordered_id_list_core #(
  parameter int DEPTH    = rol_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = rol_pkg::ID_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rol_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rol_pkg::out_item_t      out_data
);

  import rol_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rol_dpath #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
